@@ hdl/chacha_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and round functions for the ChaCha20 block cipher.
package chacha_pkg;

	localparam int DOUBLE_ROUNDS = 10;
	// Each double round takes four pipeline stages (two per column/diagonal round).
	localparam int NUM_HALF = 4 * DOUBLE_ROUNDS;

	localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
	localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
	localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
	localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_0 = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_1 = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_2 = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_3 = 2'd3;

	localparam logic [6:0] MAX_BYTES = 7'd64;

	typedef logic [15:0][31:0] state_t;
	typedef logic [3:0][63:0]  key_t;
	typedef logic [7:0][63:0]  block_t;

	typedef struct packed {
		logic [63:0] data_word_0;
		logic [63:0] data_word_1;
		logic [63:0] data_word_2;
		logic [63:0] data_word_3;
		logic [63:0] data_word_4;
		logic [63:0] data_word_5;
		logic [63:0] data_word_6;
		logic [63:0] data_word_7;
		logic [6:0]  byte_count;
		logic [31:0] block_counter;
		logic [63:0] nonce_low;
		logic [31:0] nonce_high;
	} in_t;

	typedef struct packed {
		logic [63:0] result_word_0;
		logic [63:0] result_word_1;
		logic [63:0] result_word_2;
		logic [63:0] result_word_3;
		logic [63:0] result_word_4;
		logic [63:0] result_word_5;
		logic [63:0] result_word_6;
		logic [63:0] result_word_7;
		logic [6:0]  valid_bytes;
	} out_t;

	// Payload riding alongside the cipher state.
	typedef struct packed {
		block_t      data;
		logic [6:0]  count;
		logic [31:0] ctr;
		logic [63:0] nonce_lo;
		logic [31:0] nonce_hi;
	} side_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic state_t make_state(input key_t key, input logic [31:0] ctr,
		input logic [63:0] nonce_lo, input logic [31:0] nonce_hi);
		state_t s;
		s[0] = SIGMA_0;
		s[1] = SIGMA_1;
		s[2] = SIGMA_2;
		s[3] = SIGMA_3;
		for (int i = 0; i < 4; i++) begin
			s[4 + 2 * i] = key[i][31:0];
			s[5 + 2 * i] = key[i][63:32];
		end
		s[12] = ctr;
		s[13] = nonce_lo[31:0];
		s[14] = nonce_lo[63:32];
		s[15] = nonce_hi;
		return s;
	endfunction

	// Half of a column or diagonal round: two add/xor/rotate steps of each
	// of the four quarter rounds.
	function automatic state_t round_half(input state_t s, input logic diag,
		input logic second);
		state_t r;
		logic [1:0] jb, jc, jd;
		logic [31:0] a, b, c, d;
		r = s;
		for (int i = 0; i < 4; i++) begin
			jb = 2'(i) + (diag ? 2'd1 : 2'd0);
			jc = 2'(i) + (diag ? 2'd2 : 2'd0);
			jd = 2'(i) + (diag ? 2'd3 : 2'd0);
			a = s[4'(i)];
			b = s[{2'b01, jb}];
			c = s[{2'b10, jc}];
			d = s[{2'b11, jd}];
			a = a + b;
			d = rotl(d ^ a, second ? 8 : 16);
			c = c + d;
			b = rotl(b ^ c, second ? 7 : 12);
			r[4'(i)]       = a;
			r[{2'b01, jb}] = b;
			r[{2'b10, jc}] = c;
			r[{2'b11, jd}] = d;
		end
		return r;
	endfunction

endpackage

@@ hdl/chacha20_block_cipher.sv @@
`timescale 1ns / 1ps
// ChaCha20 block cipher: fully pipelined, one 64-byte block per cycle unless the output is stalled.
//
// Usage:
//   Source channel (src_valid/src_stall/src_word) carries one word per block:
//   eight 64-bit data words, byte count, 32-bit block counter and 96-bit nonce.
//   Result channel (dst_valid/dst_stall/dst_word) returns the data XORed with
//   the keystream; bytes at or past the (saturated to 64) count read zero.
//   Key is loaded through cfg_we/cfg_index/cfg_data, 64 bits per index; the user
//   must load it only while no block is in flight (the block does not enforce this).
// Pipeline: the input stage loads at the accepting edge, then 40 round stages
//   and one finalize/output stage lead to the result on dst_word, which is
//   held there until taken.
// Throughput: one block per cycle while dst_stall does not hold the output. Each round stage does half of a
//   column or diagonal round, i.e. two dependent 32-bit add/xor/rotate steps.
// Reset: clears the key and every valid bit; payload registers are not reset.
// Stall: the whole pipeline holds while the output word waits under
//   dst_stall, and src_stall is raised in that case. Bubbles in the pipe are
//   not squeezed out; nothing is dropped or repeated.
module chacha20_block_cipher (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                src_valid,
	output logic                                src_stall,
	input  chacha_pkg::in_t                     src_word,
	output logic                                dst_valid,
	input  logic                                dst_stall,
	output chacha_pkg::out_t                    dst_word,
	input  logic                                cfg_we,
	input  logic [chacha_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [63:0]                         cfg_data
);

	localparam int N = chacha_pkg::NUM_HALF;

	chacha_pkg::key_t   key_q;

	logic               valid_s [N+1];
	chacha_pkg::state_t state_s [N+1];
	chacha_pkg::side_t  side_s  [N+1];

	logic               res_valid_q;
	chacha_pkg::out_t   res_word_q;

	logic               advance;
	chacha_pkg::side_t  side_in;
	chacha_pkg::state_t init_state;
	chacha_pkg::state_t start_state;
	chacha_pkg::state_t key_stream;
	chacha_pkg::block_t mixed;
	chacha_pkg::out_t   res_next;

	// Pipe moves whenever the output register is empty or being taken.
	assign advance   = !res_valid_q || !dst_stall;
	assign src_stall = !advance;
	assign dst_valid = res_valid_q;
	assign dst_word  = res_word_q;

	// Key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				chacha_pkg::REG_KEY_0: key_q[0] <= cfg_data;
				chacha_pkg::REG_KEY_1: key_q[1] <= cfg_data;
				chacha_pkg::REG_KEY_2: key_q[2] <= cfg_data;
				chacha_pkg::REG_KEY_3: key_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input unpack, count saturation and initial state
	always_comb begin
		side_in.data[0]  = src_word.data_word_0;
		side_in.data[1]  = src_word.data_word_1;
		side_in.data[2]  = src_word.data_word_2;
		side_in.data[3]  = src_word.data_word_3;
		side_in.data[4]  = src_word.data_word_4;
		side_in.data[5]  = src_word.data_word_5;
		side_in.data[6]  = src_word.data_word_6;
		side_in.data[7]  = src_word.data_word_7;
		side_in.count    = (src_word.byte_count > chacha_pkg::MAX_BYTES) ?
			chacha_pkg::MAX_BYTES : src_word.byte_count;
		side_in.ctr      = src_word.block_counter;
		side_in.nonce_lo = src_word.nonce_low;
		side_in.nonce_hi = src_word.nonce_high;
		init_state = chacha_pkg::make_state(key_q, src_word.block_counter,
			src_word.nonce_low, src_word.nonce_high);
	end

	// Finalize: feed-forward add, XOR into data, mask bytes past the count.
	// The user must keep the key stable while blocks are in flight (not enforced
	// here), so the start state is rebuilt here instead of being carried down the pipe.
	always_comb begin
		start_state = chacha_pkg::make_state(key_q, side_s[N].ctr,
			side_s[N].nonce_lo, side_s[N].nonce_hi);
		for (int i = 0; i < 16; i++) begin
			key_stream[i] = state_s[N][i] + start_state[i];
		end
		for (int w = 0; w < 8; w++) begin
			mixed[w] = side_s[N].data[w] ^ {key_stream[2 * w + 1], key_stream[2 * w]};
			for (int b = 0; b < 8; b++) begin
				if (7'(8 * w + b) >= side_s[N].count) begin
					mixed[w][8 * b +: 8] = 8'h00;
				end
			end
		end
		res_next.result_word_0 = mixed[0];
		res_next.result_word_1 = mixed[1];
		res_next.result_word_2 = mixed[2];
		res_next.result_word_3 = mixed[3];
		res_next.result_word_4 = mixed[4];
		res_next.result_word_5 = mixed[5];
		res_next.result_word_6 = mixed[6];
		res_next.result_word_7 = mixed[7];
		res_next.valid_bytes   = side_s[N].count;
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= N; k++) begin
				valid_s[k] <= 1'b0;
			end
			res_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s[0] <= src_valid;
			for (int k = 1; k <= N; k++) begin
				valid_s[k] <= valid_s[k-1];
			end
			res_valid_q <= valid_s[N];
		end
	end

	// Payload: stage k (k >= 1) does half-round k-1; bit 1 of that index
	// picks column or diagonal, bit 0 picks first or second half.
	always_ff @(posedge clk) begin
		if (advance) begin
			state_s[0] <= init_state;
			side_s[0]  <= side_in;
			for (int k = 1; k <= N; k++) begin
				state_s[k] <= chacha_pkg::round_half(state_s[k-1],
					1'(((k - 1) >> 1) & 1), 1'((k - 1) & 1));
				side_s[k]  <= side_s[k-1];
			end
			res_word_q <= res_next;
		end
	end

endmodule
